FILE: rtl/jpbd_pkg.sv
package jpbd_pkg;

	// Token segments, split by dots
	localparam logic [1:0] SEG_HEADER  = 2'd0;
	localparam logic [1:0] SEG_PAYLOAD = 2'd1;
	localparam logic [1:0] SEG_REST    = 2'd2;

	localparam logic [7:0] DOT_CHAR = 8'h2E;  // '.'

	localparam int unsigned ACC_W  = 12;
	localparam int unsigned PEND_W = 3;

	// One result beat as the core produces it
	typedef struct packed {
		logic       has_result;
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       token_done;
		logic       malformed;
	} jpbd_res_t;

endpackage

FILE: rtl/jpbd_sextet.sv
// base64url alphabet lookup; '-' maps like '+', '_' like '/'
module jpbd_sextet
	import jpbd_pkg::*;
(
	input  logic [7:0] char_in,
	output logic       sx_valid,
	output logic [5:0] sx_value
);

	always_comb begin
		sx_valid = 1'b1;
		sx_value = 6'd0;
		priority if (char_in >= 8'h41 && char_in <= 8'h5A) begin
			sx_value = 6'(char_in - 8'h41);
		end else if (char_in >= 8'h61 && char_in <= 8'h7A) begin
			sx_value = 6'(char_in - 8'h61 + 8'd26);
		end else if (char_in >= 8'h30 && char_in <= 8'h39) begin
			sx_value = 6'(char_in - 8'h30 + 8'd52);
		end else if (char_in == 8'h2B || char_in == 8'h2D) begin
			sx_value = 6'd62;
		end else if (char_in == 8'h2F || char_in == 8'h5F) begin
			sx_value = 6'd63;
		end else begin
			sx_valid = 1'b0;
		end
	end

endmodule

FILE: rtl/jpbd_core.sv
// Segment tracking, bit accumulator and result build for one character
module jpbd_core
	import jpbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_s1,
	input  logic       final_s1,
	input  logic       fire,
	output jpbd_res_t  res
);

	logic [1:0]        seg_q;
	logic              stopped_q;
	logic [ACC_W-1:0]  acc_q;
	logic [PEND_W-1:0] pend_q;

	logic              sx_valid;
	logic [5:0]        sx_value;
	logic              is_dot;
	logic [1:0]        seg_dot;
	logic              decode;
	logic              emit;
	logic [ACC_W-1:0]  acc_new;
	logic [PEND_W-1:0] sh;
	logic [PEND_W-1:0] pend_new;

	jpbd_sextet u_sextet (
		.char_in  (char_s1),
		.sx_valid (sx_valid),
		.sx_value (sx_value)
	);

	always_comb begin
		is_dot   = (char_s1 == DOT_CHAR);
		seg_dot  = (is_dot && seg_q != SEG_REST) ? seg_q + 2'd1 : seg_q;
		decode   = !is_dot && !final_s1 && seg_q == SEG_PAYLOAD && !stopped_q;
		acc_new  = {acc_q[ACC_W-7:0], sx_value};
		emit     = decode && sx_valid && pend_q != '0;
		sh       = pend_q - PEND_W'(2);
		pend_new = emit ? sh : PEND_W'(6);

		res = '0;
		if (final_s1) begin
			res.has_result = 1'b1;
			res.token_done = 1'b1;
			res.malformed  = (seg_dot != SEG_REST);
		end else if (emit) begin
			res.has_result = 1'b1;
			res.byte_valid = 1'b1;
			res.data_byte  = 8'(acc_new >> sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= SEG_HEADER;
			stopped_q <= 1'b0;
			acc_q     <= '0;
			pend_q    <= '0;
		end else if (fire) begin
			if (final_s1) begin
				seg_q     <= SEG_HEADER;
				stopped_q <= 1'b0;
				acc_q     <= '0;
				pend_q    <= '0;
			end else if (is_dot) begin
				seg_q <= seg_dot;
			end else if (decode) begin
				if (!sx_valid) begin
					stopped_q <= 1'b1;
				end else begin
					acc_q  <= acc_new;
					pend_q <= pend_new;
				end
			end
		end
	end

endmodule

FILE: rtl/jwt_payload_base64url_decoder.sv
// JWT payload base64url decoder.
// Input channel (in_valid/in_ready): one token character per beat, with
// final_char set on the last character of the token.
// Output channel (out_valid/out_ready): one result per beat. A byte beat
// has byte_valid set and carries a decoded payload byte. The done beat,
// produced for the last character only, has token_done set and malformed
// high when the token held fewer than two dots; the consumer then drops
// the bytes it already took for that token.
// Only the segment between the first and second dot is decoded. The first
// character there outside the alphabet halts decoding until the token ends.
// A character is held in the input register, then its result in the result
// register.
// Throughput: one character per cycle unless stalled; the input register
// frees up as soon as its character either produces no beat or finds the
// result register free or draining, so in_ready follows out_ready combinationally.
// Stall: while out_ready is low the result register holds; characters that
// produce no beat keep flowing, the next beat-producing one waits in s1.
// Reset (arst_n low): empties both registers and returns to the header
// segment with the accumulator cleared. State also clears after each done.
module jwt_payload_base64url_decoder
	import jpbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] token_char,
	input  logic       final_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       token_done,
	output logic       malformed
);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       final_s1;

	// result register
	logic       out_valid_q;
	logic [7:0] data_byte_q;
	logic       byte_valid_q;
	logic       token_done_q;
	logic       malformed_q;

	jpbd_res_t  res;
	logic       fire;

	// s1 retires when it makes no beat or the result register can take one
	assign fire     = valid_s1 && (!res.has_result || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1  <= token_char;
			final_s1 <= final_char;
		end
	end

	jpbd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_s1  (char_s1),
		.final_s1 (final_s1),
		.fire     (fire),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.has_result) begin
			data_byte_q  <= res.data_byte;
			byte_valid_q <= res.byte_valid;
			token_done_q <= res.token_done;
			malformed_q  <= res.malformed;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_byte  = data_byte_q;
	assign byte_valid = byte_valid_q;
	assign token_done = token_done_q;
	assign malformed  = malformed_q;

endmodule

FILE: rtl/jpbd_checker.sv
module jpbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_byte,
	input logic       byte_valid,
	input logic       token_done,
	input logic       malformed
);

	// each beat is exactly one kind
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({byte_valid, token_done}))
		else $error("beat is neither or both byte and done");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> !malformed)
		else $error("byte beat flagged malformed");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_done |-> data_byte == 8'd0)
		else $error("done beat carries data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte)
			&& $stable(byte_valid) && $stable(token_done) && $stable(malformed))
		else $error("stalled beat changed");

	// input stage left empty at the last edge is ready now
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_ready && !in_valid) |-> in_ready)
		else $error("input stalled with empty stage");

endmodule

bind jwt_payload_base64url_decoder jpbd_checker u_jpbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.data_byte  (data_byte),
	.byte_valid (byte_valid),
	.token_done (token_done),
	.malformed  (malformed)
);
